// ===== rtl/core/rcu_pkg.sv =====
// Package of the rate control capacity update block: types, codes and constants.
package rcu_pkg;

    localparam int QUEUES = 3;

    localparam logic       KIND_ARRIVAL = 1'b0;
    localparam logic       KIND_TICK    = 1'b1;
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_DATA  = 2'd1;
    localparam logic [1:0] CLS_ACK   = 2'd2;
    localparam logic [1:0] CLS_CTRL  = 2'd3;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_LOW    = 2'd1;
    localparam logic [1:0] ST_HIGH   = 2'd2;
    localparam logic [1:0] ST_WITHIN = 2'd3;

    localparam logic [2:0] REG_THR   = 3'd0;
    localparam logic [2:0] REG_ALPHA = 3'd1;
    localparam logic [2:0] REG_BETA  = 3'd2;
    localparam logic [2:0] REG_TQ    = 3'd3;
    localparam logic [2:0] REG_CL    = 3'd4;
    localparam logic [2:0] REG_MIN   = 3'd5;
    localparam logic [2:0] REG_MAX   = 3'd6;

    localparam logic [23:0] RST_THR   = 24'd22500;
    localparam logic [8:0]  RST_ALPHA = 9'd128;
    localparam logic [8:0]  RST_BETA  = 9'd128;
    localparam logic [23:0] RST_TQ    = 24'd12000;
    localparam logic [19:0] RST_CL    = 20'd10000;
    localparam logic [19:0] RST_MIN   = 20'd10000;
    localparam logic [19:0] RST_MAX   = 20'd10000;

    localparam int DIV_DW = 52;
    localparam int DIV_SW = 32;

    typedef struct packed {
        logic        kind;
        logic [2:0]  queue_index;
        logic [15:0] packet_bytes;
        logic [1:0]  packet_class;
        logic [23:0] rtt_ns;
        logic [23:0] queue_bytes;
    } t_in_item;

    typedef struct packed {
        logic [19:0] capacity_mbps;
        logic [1:0]  clip_status;
        logic [23:0] avg_rtt_out;
        logic        bad_queue;
    } t_out_item;

    typedef struct packed {
        logic        is_tick;
        logic        bad;
        logic        upd_rtt;
        logic        count;
        logic [15:0] bytes;
        logic [23:0] rtt;
        logic [23:0] qbytes;
    } t_cmd;

    typedef struct packed {
        logic [23:0] thr;
        logic [8:0]  alpha;
        logic [8:0]  beta;
        logic [23:0] tq;
        logic [19:0] cl;
        logic [19:0] cmin;
        logic [19:0] cmax;
    } t_cfg;

endpackage

// ===== rtl/core/rcu_front.sv =====
// Front part: accepts input items, classifies them and queues commands.
module rcu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rcu_pkg::t_in_item i_in_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output rcu_pkg::t_cmd     o_cmd
);

    rcu_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;
    rcu_pkg::t_cmd w_cmd;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cmd.is_tick = (i_in_item.kind == rcu_pkg::KIND_TICK);
        w_cmd.bad     = !w_cmd.is_tick &&
                        ({1'b0, i_in_item.queue_index} >= 4'(rcu_pkg::QUEUES));
        w_cmd.upd_rtt = (i_in_item.packet_class == rcu_pkg::CLS_DATA) &&
                        (i_in_item.rtt_ns != 24'd0);
        w_cmd.count   = (i_in_item.packet_class != rcu_pkg::CLS_OTHER);
        w_cmd.bytes   = i_in_item.packet_bytes;
        w_cmd.rtt     = i_in_item.rtt_ns;
        w_cmd.qbytes  = i_in_item.queue_bytes;
    end

    assign o_in_ready  = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("front queue count out of range");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + 2'd1)
        else $error("front queue push lost");
`endif

endmodule

// ===== rtl/core/rcu_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module rcu_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rcu_pkg::DIV_DW-1:0] i_dividend,
    input  logic [rcu_pkg::DIV_SW-1:0] i_divisor,
    output logic                       o_done,
    output logic [rcu_pkg::DIV_DW-1:0] o_quot
);

    logic                       r_busy;
    logic                       r_done;
    logic [5:0]                 r_cnt;
    logic [rcu_pkg::DIV_SW-1:0] r_rem;
    logic [rcu_pkg::DIV_SW-1:0] r_div;
    logic [rcu_pkg::DIV_DW-1:0] r_quo;
    logic [rcu_pkg::DIV_SW:0]   w_rem_sh;
    logic [rcu_pkg::DIV_SW:0]   w_diff;
    logic                       w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[rcu_pkg::DIV_DW-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
        w_diff   = w_rem_sh - {1'b0, r_div};
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[rcu_pkg::DIV_SW-1:0] : w_rem_sh[rcu_pkg::DIV_SW-1:0];
            r_quo <= {r_quo[rcu_pkg::DIV_DW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(rcu_pkg::DIV_DW - 1);
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == 6'd0 && !i_start |=> o_done)
        else $error("divider missed done");
`endif

endmodule

// ===== rtl/core/rcu_back.sv =====
// Back part: applies arrivals, runs the timeout rate computation, holds results.
module rcu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcu_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  rcu_pkg::t_cmd      i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rcu_pkg::t_out_item o_out_item
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_IN    = 11'b000_0000_0010,
        S_DR    = 11'b000_0000_0100,
        S_TERM  = 11'b000_0000_1000,
        S_GST   = 11'b000_0001_0000,
        S_G     = 11'b000_0010_0000,
        S_F     = 11'b000_0100_0000,
        S_MUL   = 11'b000_1000_0000,
        S_RATIO = 11'b001_0000_0000,
        S_PROD  = 11'b010_0000_0000,
        S_CLIP  = 11'b100_0000_0000
    } t_state;

    localparam logic [47:0] ACC_TOP = 48'h8000_0001_0000;

    t_state r_state, n_state;

    logic [31:0]               r_avg;
    logic [31:0]               r_ib;
    logic [19:0]               r_adv;
    logic                      r_out_valid;
    rcu_pkg::t_out_item        r_out;
    logic [23:0]               r_qbytes;
    logic [31:0]               r_in;
    logic [31:0]               r_drain;
    logic                      r_dneg;
    logic [41:0]               r_tmag;
    logic                      r_gneg;
    logic [49:0]               r_gmag;
    logic [47:0]               r_f;
    logic [47:0]               r_acc;
    logic [5:0]                r_cnt;
    logic signed [31:0]        r_ratio;
    logic signed [52:0]        r_temp;

    logic                      w_can_load;
    logic                      w_take;
    logic                      w_div_start;
    logic [rcu_pkg::DIV_DW-1:0] w_div_dividend;
    logic [rcu_pkg::DIV_SW-1:0] w_div_divisor;
    logic                      w_div_done;
    logic [rcu_pkg::DIV_DW-1:0] w_quot;
    logic [31:0]               w_quot_sat;
    logic [23:0]               w_tq1;
    logic [19:0]               w_cl1;
    logic [31:0]               w_rtt1;
    logic [44:0]               w_in_prod;
    logic [23:0]               w_qdiff;
    logic [44:0]               w_dr_prod;
    logic [32:0]               w_avg_sum;
    logic [32:0]               w_ib_sum;
    logic signed [33:0]        w_cmi;
    logic signed [33:0]        w_dr_s;
    logic signed [43:0]        w_ta;
    logic signed [43:0]        w_tb;
    logic signed [44:0]        w_term;
    logic [44:0]               w_term_abs;
    logic [49:0]               w_sum;
    logic [31:0]               w_p;
    logic signed [33:0]        w_ratio_w;
    logic signed [52:0]        w_lo;
    logic signed [52:0]        w_hi;

    rcu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_can_load  = !r_out_valid || i_out_ready;
        o_cmd_ready = (r_state == S_IDLE) && w_can_load;
        w_take      = i_cmd_valid && o_cmd_ready;
        w_tq1       = (i_cfg.tq == 24'd0) ? 24'd1 : i_cfg.tq;
        w_cl1       = (i_cfg.cl == 20'd0) ? 20'd1 : i_cfg.cl;
        w_rtt1      = (r_avg == 32'd0) ? 32'd1 : r_avg;
        w_quot_sat  = (w_quot[rcu_pkg::DIV_DW-1:32] != '0) ? 32'hFFFF_FFFF : w_quot[31:0];
        w_in_prod   = 45'(r_ib) * 45'(8000);
        w_qdiff     = (r_qbytes >= i_cfg.thr) ? (r_qbytes - i_cfg.thr)
                                              : (i_cfg.thr - r_qbytes);
        w_dr_prod   = 45'(w_qdiff) * 45'(2048000);
        w_avg_sum   = {1'b0, i_cmd.rtt, 8'd0} + {1'b0, r_avg};
        w_ib_sum    = {1'b0, r_ib} + 33'(i_cmd.bytes);
        w_cmi       = $signed({14'd0, w_cl1}) - $signed({2'b0, r_in});
        w_dr_s      = r_dneg ? -$signed({2'b0, r_drain}) : $signed({2'b0, r_drain});
        w_ta        = $signed({1'b0, i_cfg.alpha}) * w_cmi;
        w_tb        = $signed({1'b0, i_cfg.beta}) * w_dr_s;
        w_term      = 45'(w_ta) - 45'(w_tb);
        w_term_abs  = w_term[44] ? 45'(-w_term) : 45'(w_term);
        w_sum       = 50'({r_acc, 1'b0}) + (r_gmag[r_cnt] ? 50'(r_f) : 50'd0);
        w_p         = (r_acc[47:16] > 32'h8000_0000) ? 32'h8000_0000 : r_acc[47:16];
        w_ratio_w   = r_gneg ? (34'sd65536 - $signed({2'b0, w_p}))
                             : (34'sd65536 + $signed({2'b0, w_p}));
        w_lo        = $signed({17'd0, i_cfg.cmin, 16'd0});
        w_hi        = $signed({17'd0, i_cfg.cmax, 16'd0});
    end

    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = rcu_pkg::DIV_DW'(w_in_prod);
        w_div_divisor  = rcu_pkg::DIV_SW'(w_tq1);
        unique case (r_state)
            S_IDLE: begin
                w_div_start = w_take && i_cmd.is_tick;
            end
            S_IN: begin
                w_div_start    = w_div_done;
                w_div_dividend = rcu_pkg::DIV_DW'(w_dr_prod);
                w_div_divisor  = w_rtt1;
            end
            S_GST: begin
                w_div_start    = 1'b1;
                w_div_dividend = rcu_pkg::DIV_DW'({r_tmag, 8'd0});
                w_div_divisor  = rcu_pkg::DIV_SW'(w_cl1);
            end
            S_G: begin
                w_div_start    = w_div_done;
                w_div_dividend = rcu_pkg::DIV_DW'({w_tq1, 24'd0});
                w_div_divisor  = w_rtt1;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_take && i_cmd.is_tick) n_state = S_IN;
            S_IN:    if (w_div_done) n_state = S_DR;
            S_DR:    if (w_div_done) n_state = S_TERM;
            S_TERM:  n_state = S_GST;
            S_GST:   n_state = S_G;
            S_G:     if (w_div_done) n_state = S_F;
            S_F:     if (w_div_done) n_state = S_MUL;
            S_MUL:   if (r_cnt == 6'd0) n_state = S_RATIO;
            S_RATIO: n_state = S_PROD;
            S_PROD:  n_state = S_CLIP;
            S_CLIP:  if (w_can_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_qbytes <= i_cmd.qbytes;
            end
            S_IN: begin
                r_in   <= w_quot_sat;
                r_dneg <= (r_qbytes < i_cfg.thr);
            end
            S_DR: begin
                r_drain <= w_quot_sat;
            end
            S_TERM: begin
                r_tmag <= w_term_abs[41:0];
                r_gneg <= w_term[44];
            end
            S_G: begin
                r_gmag <= w_quot[49:0];
            end
            S_F: begin
                r_f   <= w_quot[47:0];
                r_acc <= '0;
                r_cnt <= 6'd49;
            end
            S_MUL: begin
                r_acc <= (w_sum > 50'(ACC_TOP)) ? ACC_TOP : w_sum[47:0];
                r_cnt <= r_cnt - 6'd1;
            end
            S_RATIO: begin
                r_ratio <= (w_ratio_w > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                         : 32'(w_ratio_w);
            end
            S_PROD: begin
                r_temp <= 53'($signed({1'b0, r_adv})) * 53'(r_ratio);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_avg       <= {rcu_pkg::RST_TQ, 8'd0};
            r_ib        <= '0;
            r_adv       <= rcu_pkg::RST_CL;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take && !i_cmd.is_tick) begin
                r_out_valid           <= 1'b1;
                r_out.capacity_mbps   <= r_adv;
                r_out.clip_status     <= rcu_pkg::ST_NONE;
                r_out.bad_queue       <= i_cmd.bad;
                r_out.avg_rtt_out     <= r_avg[31:8];
                if (!i_cmd.bad) begin
                    if (i_cmd.upd_rtt) begin
                        r_avg             <= w_avg_sum[32:1];
                        r_out.avg_rtt_out <= w_avg_sum[32:9];
                    end
                    if (i_cmd.count) begin
                        r_ib <= w_ib_sum[32] ? 32'hFFFF_FFFF : w_ib_sum[31:0];
                    end
                end
            end
            if (r_state == S_CLIP && w_can_load) begin
                r_out_valid       <= 1'b1;
                r_out.bad_queue   <= 1'b0;
                r_out.avg_rtt_out <= r_avg[31:8];
                r_ib              <= '0;
                if (r_temp < w_lo) begin
                    r_adv               <= i_cfg.cmin;
                    r_out.capacity_mbps <= i_cfg.cmin;
                    r_out.clip_status   <= rcu_pkg::ST_LOW;
                end else if (r_temp > w_hi) begin
                    r_adv               <= i_cfg.cmax;
                    r_out.capacity_mbps <= i_cfg.cmax;
                    r_out.clip_status   <= rcu_pkg::ST_HIGH;
                end else begin
                    r_adv               <= r_temp[35:16];
                    r_out.capacity_mbps <= r_temp[35:16];
                    r_out.clip_status   <= rcu_pkg::ST_WITHIN;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_bad_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bad_queue |-> r_out.clip_status == rcu_pkg::ST_NONE)
        else $error("ignored arrival reported a capacity update");
    a_mul_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL && r_cnt == 6'd0 |=> r_state == S_RATIO)
        else $error("multiply sequence overran");
`endif

endmodule

// ===== rtl/core/rate_control_capacity_update_top.sv =====
// Top level of the rate control capacity update block.
// An arrival item is applied as it is taken, and the block sustains one arrival per cycle when
// the result side keeps up and no timeout tick is running. A timeout tick runs four 52-step
// divisions on one shared iterative divider plus a 50-step multiply, while later items wait in
// the two-entry command queue. Configuration writes complete in the cycle they are offered.
module rate_control_capacity_update_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rcu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rcu_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    rcu_pkg::t_cfg r_cfg;
    logic          w_cmd_valid;
    logic          w_cmd_ready;
    rcu_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr   <= rcu_pkg::RST_THR;
            r_cfg.alpha <= rcu_pkg::RST_ALPHA;
            r_cfg.beta  <= rcu_pkg::RST_BETA;
            r_cfg.tq    <= rcu_pkg::RST_TQ;
            r_cfg.cl    <= rcu_pkg::RST_CL;
            r_cfg.cmin  <= rcu_pkg::RST_MIN;
            r_cfg.cmax  <= rcu_pkg::RST_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rcu_pkg::REG_THR:   r_cfg.thr   <= i_cfg_data;
                rcu_pkg::REG_ALPHA: r_cfg.alpha <= i_cfg_data[8:0];
                rcu_pkg::REG_BETA:  r_cfg.beta  <= i_cfg_data[8:0];
                rcu_pkg::REG_TQ:    r_cfg.tq    <= i_cfg_data;
                rcu_pkg::REG_CL:    r_cfg.cl    <= i_cfg_data[19:0];
                rcu_pkg::REG_MIN:   r_cfg.cmin  <= i_cfg_data[19:0];
                rcu_pkg::REG_MAX:   r_cfg.cmax  <= i_cfg_data[19:0];
                default:            r_cfg       <= r_cfg;
            endcase
        end
    end

    rcu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    rcu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
